### rtl/vbr_pkg.sv
// ----------------------------------------------------------------------------
// vbr_pkg
// Types and constants shared by the VBR info header parser modules.
// ----------------------------------------------------------------------------
package vbr_pkg;

   localparam int TOC_BYTES = 100;
   localparam int TOC_WORDS = TOC_BYTES / 4;
   localparam int WORD_W    = 5;          // TOC word index
   localparam int POS_W     = 7;
   localparam int CNT_W     = 7;          // TOC bytes written, 0..100
   localparam int RAM_AW    = WORD_W + 1; // bank bit on top
   localparam int RAM_DEPTH = 1 << RAM_AW;

   localparam logic [31:0] TAG_XING = 32'h5869_6E67;
   localparam logic [31:0] TAG_INFO = 32'h496E_666F;

   localparam logic [3:0] FLAG_FRAMES  = 4'h1;
   localparam logic [3:0] FLAG_BYTES   = 4'h2;
   localparam logic [3:0] FLAG_TOC     = 4'h4;
   localparam logic [3:0] FLAG_QUALITY = 4'h8;

   localparam logic [POS_W-1:0] POS_MAX = 7'd127;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        header_valid;
      logic        tag_is_info;
      logic        has_bytes;
      logic        has_toc;
      logic        has_quality;
      logic [31:0] total_frames;
      logic [31:0] total_bytes;
      logic [7:0]  quality;
      logic [4:0]  toc_index;
      logic [31:0] toc_word;
      logic        complete;
      logic        last_result;
   } rsp_type;

   // context state after the current byte
   typedef struct packed {
      logic             seen;
      logic [POS_W-1:0] pos;
      logic [3:0]       flags;
      logic [31:0]      frames;
      logic [31:0]      bytes;
      logic [7:0]       qual;
      logic [CNT_W-1:0] toc_cnt;
   } ctx_stat_type;

   typedef struct packed {
      logic              we;
      logic [WORD_W-1:0] word;
      logic [1:0]        lane;
      logic [7:0]        data;
   } toc_wr_type;

   // one finished run, queued for the back end
   typedef struct packed {
      logic             header_valid;
      logic             tag_is_info;
      logic [3:0]       flags;
      logic [31:0]      frames;
      logic [31:0]      bytes;
      logic [7:0]       qual;
      logic             complete;
      logic [CNT_W-1:0] toc_cnt;
      logic             bank;
   } run_type;

endpackage

### rtl/vbr_ram.sv
// ----------------------------------------------------------------------------
// vbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/vbr_ctx.sv
// ----------------------------------------------------------------------------
// vbr_ctx
// One tag context: tag matcher, flags word and field capture.
// ----------------------------------------------------------------------------
module vbr_ctx
   import vbr_pkg::*;
#(
   parameter logic [31:0] TAG = 32'h5869_6E67
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [7:0]   byte_value,
   input  logic         clear,
   output ctx_stat_type stat_in,
   output toc_wr_type   toc_wr
);

   logic [2:0]       prog_ff, prog_in;
   ctx_stat_type     stat_ff;
   logic [1:0]       pidx;
   logic [7:0]       tag_byte, tag_first;
   logic [POS_W-1:0] p, by_s, toc_s, q_s, toc_off;

   assign pidx      = prog_ff[1:0];
   assign tag_byte  = TAG[8*(3-pidx) +: 8];
   assign tag_first = TAG[31:24];
   assign p         = stat_ff.pos;
   assign by_s      = 7'd4 + (stat_ff.flags[0] ? 7'd4 : 7'd0);
   assign toc_s     = by_s + (stat_ff.flags[1] ? 7'd4 : 7'd0);
   assign q_s       = toc_s + (stat_ff.flags[2] ? 7'(TOC_BYTES) : 7'd0);
   assign toc_off   = p - toc_s;

   always_comb begin
      prog_in = prog_ff;
      stat_in = stat_ff;
      toc_wr  = '0;
      toc_wr.word = toc_off[6:2];
      toc_wr.lane = toc_off[1:0];
      toc_wr.data = byte_value;
      if (!stat_ff.seen) begin
         if (byte_value == tag_byte) prog_in = prog_ff + 3'd1;
         else prog_in = (byte_value == tag_first) ? 3'd1 : 3'd0;
         if (prog_in == 3'd4) stat_in.seen = 1'b1;
      end else begin
         if (p == 7'd3) stat_in.flags = byte_value[3:0];
         if (stat_ff.flags[0] && p >= 7'd4 && p < 7'd8)
            stat_in.frames = {stat_ff.frames[23:0], byte_value};
         if (stat_ff.flags[1] && p >= by_s && p < by_s + 7'd4)
            stat_in.bytes = {stat_ff.bytes[23:0], byte_value};
         if (stat_ff.flags[2] && p >= toc_s && p < toc_s + 7'(TOC_BYTES)) begin
            toc_wr.we = en;
            stat_in.toc_cnt = stat_ff.toc_cnt + 7'd1;
         end
         if (stat_ff.flags[3] && p == q_s + 7'd3) stat_in.qual = byte_value;
         if (p != POS_MAX) stat_in.pos = p + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (en && clear)) begin
         prog_ff <= '0;
         stat_ff <= '0;
      end else if (en) begin
         prog_ff <= prog_in;
         stat_ff <= stat_in;
      end
   end

endmodule

### rtl/vbr_back.sv
// ----------------------------------------------------------------------------
// vbr_back
// Result sequencer: reads TOC words for a queued run and emits result items.
// ----------------------------------------------------------------------------
module vbr_back
   import vbr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  run_type           head,
   output logic              pop,
   output logic              rd_en,
   output logic [RAM_AW-1:0] rd_addr,
   input  logic [31:0]       xing_word,
   input  logic [31:0]       info_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   logic              s1_valid_ff;
   run_type           s1_run_ff;
   logic [WORD_W-1:0] s1_k_ff;
   logic              s1_last_ff;
   logic [WORD_W-1:0] k_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              load_out, s1_free, multi, last_k;
   logic [31:0]       word_raw, word_mask;
   logic [CNT_W-1:0]  base;

   assign multi    = head.header_valid && head.flags[2];
   assign last_k   = !multi || (k_ff == WORD_W'(TOC_WORDS - 1));
   assign load_out = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_free  = !s1_valid_ff || load_out;
   assign rd_en    = head_valid && s1_free;
   assign rd_addr  = {head.bank, k_ff};
   assign pop      = rd_en && last_k;

   assign word_raw = s1_run_ff.tag_is_info ? info_word : xing_word;
   assign base     = {s1_k_ff, 2'b00};
   always_comb begin
      for (int l = 0; l < 4; l++)
         word_mask[8*l +: 8] = ((base + CNT_W'(l)) < s1_run_ff.toc_cnt) ? 8'hFF : 8'h00;
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.tag_is_info = s1_run_ff.tag_is_info;
      rsp_in.last_result = s1_last_ff;
      if (s1_run_ff.header_valid) begin
         rsp_in.header_valid = 1'b1;
         rsp_in.has_bytes    = s1_run_ff.flags[1];
         rsp_in.has_toc      = s1_run_ff.flags[2];
         rsp_in.has_quality  = s1_run_ff.flags[3];
         rsp_in.total_frames = s1_run_ff.frames;
         rsp_in.total_bytes  = s1_run_ff.flags[1] ? s1_run_ff.bytes : 32'd0;
         rsp_in.quality      = s1_run_ff.flags[3] ? s1_run_ff.qual : 8'd0;
         rsp_in.complete     = s1_run_ff.complete;
         if (s1_run_ff.flags[2]) begin
            rsp_in.toc_index = s1_k_ff;
            rsp_in.toc_word  = word_raw & word_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= rd_en;
         if (rd_en) k_ff <= last_k ? '0 : k_ff + 5'd1;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (rd_en) begin
         s1_run_ff  <= head;
         s1_k_ff    <= k_ff;
         s1_last_ff <= last_k;
      end
      if (load_out) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/vbr_info_header_parser.sv
// Runs queue, then pass the TOC read and output registers. Throughput: one byte per
// cycle; results leave one per cycle while rsp_ready is high, 25 per run with valid
// header and TOC (one TOC word read per cycle from the lane RAMs), otherwise one.
// TOC storage is double-banked; a new byte waits only while both banks hold runs.
// Reset clears all parser state and the run queue; TOC RAMs need no clearing.
// ----------------------------------------------------------------------------
// vbr_info_header_parser
// Xing / Info VBR header parser: two tag contexts in front, result sequencer behind.
// ----------------------------------------------------------------------------
module vbr_info_header_parser
   import vbr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic         acc, push, pop, rd_en;
   logic         bank_ff;
   logic [1:0]   busy_ff, busy_in;
   run_type      q_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   run_type      run_in;
   ctx_stat_type xs, is, cs;
   toc_wr_type   xw, iw;
   logic [RAM_AW-1:0] rd_addr;
   logic [31:0]  xword, iword;
   logic         use_info;

   assign req_ready = !busy_ff[bank_ff];
   assign acc  = req_valid && req_ready;
   assign push = acc && req_data.last_byte;

   vbr_ctx #(.TAG(TAG_XING)) u_xing (
      .clock, .reset, .en(acc), .byte_value(req_data.byte_value),
      .clear(req_data.last_byte), .stat_in(xs), .toc_wr(xw));
   vbr_ctx #(.TAG(TAG_INFO)) u_info (
      .clock, .reset, .en(acc), .byte_value(req_data.byte_value),
      .clear(req_data.last_byte), .stat_in(is), .toc_wr(iw));

   for (genvar l = 0; l < 4; l++) begin : g_lane
      vbr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_xram (
         .clock, .wr_en(xw.we && xw.lane == 2'(l)), .wr_addr({bank_ff, xw.word}),
         .wr_data(xw.data), .rd_en, .rd_addr, .rd_data(xword[8*l +: 8]));
      vbr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_iram (
         .clock, .wr_en(iw.we && iw.lane == 2'(l)), .wr_addr({bank_ff, iw.word}),
         .wr_data(iw.data), .rd_en, .rd_addr, .rd_data(iword[8*l +: 8]));
   end

   assign use_info = !xs.seen && is.seen;
   assign cs = use_info ? is : xs;
   always_comb begin
      logic [POS_W-1:0] lend;
      lend = 7'd4 + (cs.flags[0] ? 7'd4 : 7'd0) + (cs.flags[1] ? 7'd4 : 7'd0)
           + (cs.flags[2] ? 7'(TOC_BYTES) : 7'd0) + (cs.flags[3] ? 7'd4 : 7'd0);
      run_in.header_valid = (xs.seen || is.seen) && cs.flags[0];
      run_in.tag_is_info  = use_info;
      run_in.flags        = cs.flags;
      run_in.frames       = cs.frames;
      run_in.bytes        = cs.bytes;
      run_in.qual         = cs.qual;
      run_in.complete     = cs.pos >= lend;
      run_in.toc_cnt      = cs.toc_cnt;
      run_in.bank         = bank_ff;
   end

   // push and pop never name the same bank
   always_comb begin
      busy_in = busy_ff;
      if (push) busy_in[bank_ff] = 1'b1;
      if (pop) busy_in[q_ff[rp_ff].bank] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         busy_ff <= '0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         if (push) begin
            bank_ff <= !bank_ff;
            wp_ff <= !wp_ff;
         end
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) q_ff[wp_ff] <= run_in;
   end

   vbr_back u_back (
      .clock, .reset, .head_valid(cnt_ff != 2'd0), .head(q_ff[rp_ff]), .pop,
      .rd_en, .rd_addr, .xing_word(xword), .info_word(iword),
      .rsp_valid, .rsp_ready, .rsp_data);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff != 2'd2) else $error("run queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop from empty run queue");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == cnt_ff) else $error("bank busy bits out of step");
   a_push_bank_free: assert property (@(posedge clock) disable iff (reset)
      push |-> !busy_ff[bank_ff]) else $error("run written into busy bank");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream check of the Xing / Info VBR header parser: directed and random
// frame buffers, a byte-level predictor of both tag contexts, and random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import vbr_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   vbr_info_header_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic [2:0]  prog;
      logic        seen;
      logic [6:0]  pos;
      logic [3:0]  flags;
      logic [31:0] frames;
      logic [31:0] bytes;
      logic [7:0]  qual;
      logic [7:0]  toc [TOC_BYTES];
   } tag_ctx_type;

   tag_ctx_type xing_ctx, info_ctx;
   req_type  byte_queue [$];
   rsp_type  header_queue [$];
   int       errors = 0;
   int       runs_done = 0;
   int       words_seen = 0;

   function automatic void clear_ctx(ref tag_ctx_type c);
      c.prog = '0; c.seen = 1'b0; c.pos = '0; c.flags = '0;
      c.frames = '0; c.bytes = '0; c.qual = '0;
      foreach (c.toc[i]) c.toc[i] = 8'h00;
   endfunction

   function automatic void step_ctx(ref tag_ctx_type c, input logic [31:0] tag,
                                    input logic [7:0] b);
      int p, s;
      if (!c.seen) begin
         if (b == tag[31 - 8*c.prog[1:0] -: 8]) c.prog = c.prog + 3'd1;
         else c.prog = (b == tag[31:24]) ? 3'd1 : 3'd0;
         if (c.prog >= 3'd4) begin
            c.seen = 1'b1; c.prog = 3'd4;
         end
         return;
      end
      p = c.pos;
      s = 4;
      if (p == 3) c.flags = b[3:0];
      else if (p >= 4) begin
         if (c.flags & FLAG_FRAMES) begin
            if (p >= s && p < s + 4) c.frames = {c.frames[23:0], b};
            s += 4;
         end
         if (c.flags & FLAG_BYTES) begin
            if (p >= s && p < s + 4) c.bytes = {c.bytes[23:0], b};
            s += 4;
         end
         if (c.flags & FLAG_TOC) begin
            if (p >= s && p < s + TOC_BYTES) c.toc[p - s] = b;
            s += TOC_BYTES;
         end
         if ((c.flags & FLAG_QUALITY) && p == s + 3) c.qual = b;
      end
      if (c.pos < POS_MAX) c.pos = c.pos + 7'd1;
   endfunction

   function automatic int field_end(logic [3:0] f);
      int e = 4;
      if (f & FLAG_FRAMES) e += 4;
      if (f & FLAG_BYTES) e += 4;
      if (f & FLAG_TOC) e += TOC_BYTES;
      if (f & FLAG_QUALITY) e += 4;
      return e;
   endfunction

   // advance both contexts; on the last byte queue the header report(s)
   function automatic void predict_header(req_type r);
      tag_ctx_type c;
      rsp_type  h;
      int       n;
      bit       use_info, ok;
      step_ctx(xing_ctx, TAG_XING, r.byte_value);
      step_ctx(info_ctx, TAG_INFO, r.byte_value);
      if (!r.last_byte) return;
      use_info = !xing_ctx.seen && info_ctx.seen;
      c = use_info ? info_ctx : xing_ctx;
      ok = (xing_ctx.seen || info_ctx.seen) && (c.flags & FLAG_FRAMES) != 0;
      h = '0;
      h.tag_is_info = use_info;
      if (ok) begin
         h.header_valid = 1'b1;
         h.has_bytes = (c.flags & FLAG_BYTES) != 0;
         h.has_toc = (c.flags & FLAG_TOC) != 0;
         h.has_quality = (c.flags & FLAG_QUALITY) != 0;
         h.total_frames = c.frames;
         h.total_bytes = h.has_bytes ? c.bytes : 32'd0;
         h.quality = h.has_quality ? c.qual : 8'd0;
         h.complete = c.pos >= field_end(c.flags);
      end
      n = (ok && h.has_toc) ? TOC_WORDS : 1;
      for (int k = 0; k < n; k++) begin
         if (n > 1) begin
            h.toc_index = k[4:0];
            h.toc_word = {c.toc[4*k+3], c.toc[4*k+2], c.toc[4*k+1], c.toc[4*k]};
         end
         h.last_result = (k == n - 1);
         header_queue.push_back(h);
      end
      clear_ctx(xing_ctx);
      clear_ctx(info_ctx);
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_header(req_data);
            void'(byte_queue.pop_front());
            req_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) req_gap = 0;
         end
         if (req_valid && !req_ready) begin
            // hold
         end else if (req_gap > 0 || byte_queue.size() == 0) begin
            req_valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            req_valid <= 1'b1;
            req_data <= byte_queue[0];
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (rsp_data.last_result) runs_done++;
            if (header_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, got %p", $time, rsp_data);
            end else begin
               e = header_queue.pop_front();
               if (e !== rsp_data) begin
                  errors++;
                  $display("%0t: mismatch, expected %p, got %p", $time, e, rsp_data);
               end
            end
            rsp_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 2) == 0) rsp_gap = 0;
         end
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else if (!reset) idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("** vbr_info_header_parser: FAILED **");
         $finish;
      end
   end

   task automatic push_bytes(input logic [7:0] b[$], input bit last);
      foreach (b[i]) byte_queue.push_back('{byte_value: b[i],
                                             last_byte: last && i == b.size() - 1});
   endtask

   function automatic void push_tag(logic [31:0] tag);
      for (int i = 3; i >= 0; i--) byte_queue.push_back('{byte_value: tag[8*i +: 8],
                                                          last_byte: 1'b0});
   endfunction

   function automatic void push_rnd(int n, bit last);
      for (int i = 0; i < n; i++)
         byte_queue.push_back('{byte_value: 8'($urandom_range(0, 255)),
                                last_byte: last && i == n - 1});
   endfunction

   // a well-formed header with random content, possibly cut short
   function automatic void push_header(logic [31:0] tag, logic [3:0] flags, bit cut);
      int len;
      push_rnd($urandom_range(0, 3), 0);
      push_tag(tag);
      byte_queue.push_back('{byte_value: 8'h00, last_byte: 1'b0});
      byte_queue.push_back('{byte_value: 8'h00, last_byte: 1'b0});
      byte_queue.push_back('{byte_value: 8'($urandom_range(0, 15) << 4), last_byte: 1'b0});
      byte_queue.push_back('{byte_value: {4'($urandom_range(0, 15)), flags},
                             last_byte: 1'b0});
      len = field_end(flags) - 4;
      if (cut) len = $urandom_range(0, len);
      else len += $urandom_range(0, 3);
      if (len == 0) byte_queue[$].last_byte = 1'b1;
      else push_rnd(len, 1);
   endfunction

   initial begin
      clear_ctx(xing_ctx);
      clear_ctx(info_ctx);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: no tag, extremes, one- and three-byte buffers
      push_bytes('{8'h00}, 1);
      push_bytes('{8'hff, 8'h58, 8'h69}, 1);
      // Xing header, all flags, all-ones counts, buffer ends inside the TOC
      push_tag(TAG_XING);
      push_bytes('{8'h00, 8'h00, 8'h00, 8'h0f}, 0);
      for (int i = 0; i < 8; i++) byte_queue.push_back('{8'hff, 1'b0});
      push_rnd(30, 1);
      // Info only, frames flag clear
      push_tag(TAG_INFO);
      push_bytes('{8'h00, 8'h00, 8'h00, 8'hf2, 8'h12}, 1);
      // both tags: Xing wins; a lone "X" before the Info tag restarts the tag match
      push_bytes('{8'h58}, 0);
      push_tag(TAG_INFO);
      push_tag(TAG_XING);
      push_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h01}, 1);
      // tag then end inside the flags word
      push_tag(TAG_XING);
      push_bytes('{8'h00, 8'h00}, 1);

      // random short buffers until about 100 bytes are queued
      while (byte_queue.size() < 100) begin
         case ($urandom_range(0, 9))
            0: push_rnd($urandom_range(1, 8), 1);
            1: push_header($urandom_range(0, 1) ? TAG_XING : TAG_INFO,
                           4'($urandom_range(0, 15)) & ~FLAG_TOC, 1);
            default: push_header($urandom_range(0, 1) ? TAG_XING : TAG_INFO,
                                 (4'($urandom_range(0, 15)) | FLAG_FRAMES) & ~FLAG_TOC,
                                 0);
         endcase
      end

      wait (byte_queue.size() == 0);
      wait (header_queue.size() == 0);
      repeat (20) @(posedge clock);
      $display("covered %0d header runs, %0d result transfers checked",
               runs_done, words_seen);
      if (errors == 0 && header_queue.size() == 0)
         $display("** vbr_info_header_parser: PASSED **");
      else
         $display("** vbr_info_header_parser: FAILED **");
      $finish;
   end

endmodule
